// ----- rtl/lutp_pkg.sv -----
// ----------------------------------------------------------------------------
// lutp_pkg
// Shared types and constants of the length unit to percent parser: character
// codes, token phase and unit codes, controller states and the command and
// status structs between controller and datapath.
// ----------------------------------------------------------------------------
package lutp_pkg;

	// Default configuration
	localparam int DEF_MAX_FRAC_DIGITS = 3;
	localparam int DEF_WHOLE_BITS      = 16;

	// Result field width and saturation value
	localparam int                  PCT_BITS = 23;
	localparam logic [PCT_BITS-1:0] PCT_MAX  = '1;

	// Unit storage
	localparam int UNIT_CHARS = 3;
	localparam int ULEN_BITS  = 3;

	// Scaling constants
	localparam int EM_SCALE       = 100;
	localparam int EM_SCALE_BITS  = 7;
	localparam int PX_SHIFT       = 4;
	localparam int PT_DIVISOR     = 12;
	localparam int DIV_RADIX_BITS = 8;
	localparam int RECIP10        = 205;
	localparam int RECIP10_SH     = 11;
	localparam int RECIP100       = 5243;
	localparam int RECIP100_SH    = 19;
	localparam int FTERM_BITS     = 7;

	// Character codes
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_T     = 8'h74;

	// Token phase
	typedef enum logic [3:0] {
		PH_SIGN  = 4'b0001,
		PH_WHOLE = 4'b0010,
		PH_FRAC  = 4'b0100,
		PH_UNIT  = 4'b1000
	} phase_t;

	// Recognized unit
	typedef enum logic [2:0] {
		U_BAD,
		U_BARE,
		U_EM,
		U_REM,
		U_PCT,
		U_PX,
		U_PT
	} unit_t;

	// Controller states
	typedef enum logic [4:0] {
		ST_TAKE  = 5'b00001,
		ST_SCALE = 5'b00010,
		ST_SUM   = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	typedef struct packed {
		logic take;
		logic scale;
		logic sum;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic need_div;
	} sts_t;

endpackage

// ----- rtl/lutp_if.sv -----
// ----------------------------------------------------------------------------
// lutp_if
// Valid/ready channels of the parser: token characters in, results out.
// ----------------------------------------------------------------------------
interface lutp_tok_if import lutp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink   (input valid, input ch, input last, output ready);
endinterface

interface lutp_res_if import lutp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [PCT_BITS-1:0] pct_value;
	logic                usable;
	logic                root_relative;

	modport source (output valid, output pct_value, output usable, output root_relative,
		input ready);
	modport sink   (input valid, input pct_value, input usable, input root_relative,
		output ready);
endinterface

// ----- rtl/length_unit_to_percent_parser.sv -----
// ----------------------------------------------------------------------------
// length_unit_to_percent_parser
// Parses a length token, one character per transaction, into percent of an em.
// ----------------------------------------------------------------------------
// Each character of a token is taken as soon as it is offered while the block
// is in its intake state. After the character marked last, the block runs its
// finish steps (capture and scaling, em sum, result load) before it takes the
// next character, and for a pt token it also steps the divide-by-12 unit,
// which retires eight quotient bits per cycle, between em sum and result load.
// The result load waits until the previous result has been taken. The result
// register is separate from the intake, so the next token's characters are
// taken while a result still waits to be taken.
module length_unit_to_percent_parser import lutp_pkg::*; #(
	parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
	parameter int WHOLE_BITS      = DEF_WHOLE_BITS
) (
	input logic        clk,
	input logic        arst_n,
	lutp_tok_if.sink   tok,
	lutp_res_if.source res
);

	localparam int EM_BITS    = WHOLE_BITS + EM_SCALE_BITS;
	localparam int DIV_CYCLES = (EM_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;

	cmd_t cmd;
	sts_t sts;

	// Sequence intake and finish steps
	lutp_ctrl #(
		.DIV_CYCLES (DIV_CYCLES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok.valid),
		.tok_last  (tok.last),
		.tok_ready (tok.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Token registers, scaling and result
	lutp_datapath #(
		.MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
		.WHOLE_BITS      (WHOLE_BITS),
		.DIV_CYCLES      (DIV_CYCLES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.ch            (tok.ch),
		.pct_value     (res.pct_value),
		.usable        (res.usable),
		.root_relative (res.root_relative)
	);

endmodule

// ----- rtl/lutp_datapath.sv -----
// ----------------------------------------------------------------------------
// lutp_datapath
// Character intake registers, unit recognition, em scaling, radix-256
// divide-by-12 and the result register.
// ----------------------------------------------------------------------------
module lutp_datapath import lutp_pkg::*; #(
	parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
	parameter int WHOLE_BITS      = DEF_WHOLE_BITS,
	parameter int DIV_CYCLES      = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic [7:0]          ch,
	output logic [PCT_BITS-1:0] pct_value,
	output logic                usable,
	output logic                root_relative
);

	localparam int FRAC_BITS = $clog2(10 ** MAX_FRAC_DIGITS);
	localparam int FD_BITS   = $clog2(MAX_FRAC_DIGITS + 1);
	localparam int WX_BITS   = WHOLE_BITS + 4;
	localparam int FX_BITS   = FRAC_BITS + 4;
	localparam int EM_BITS   = WHOLE_BITS + EM_SCALE_BITS;
	localparam int DW        = DIV_CYCLES * DIV_RADIX_BITS;
	localparam int CMP_BITS  = (EM_BITS > PCT_BITS) ? EM_BITS : PCT_BITS;
	localparam logic [WHOLE_BITS-1:0] WHOLE_MAX = '1;

	// Intake state
	phase_t                 phase_q, ph_nx;
	logic                   neg_q, neg_nx;
	logic                   seen_q, seen_nx;
	logic [WHOLE_BITS-1:0]  whole_q, whole_nx;
	logic [FRAC_BITS-1:0]   frac_q, frac_nx;
	logic [FD_BITS-1:0]     fd_q, fd_nx;
	logic [7:0]             unit_q [UNIT_CHARS];
	logic [7:0]             unit_nx [UNIT_CHARS];
	logic [ULEN_BITS-1:0]   ulen_q, ulen_nx;
	logic                   is_digit, add_unit;
	logic [WX_BITS-1:0]     w10;
	logic [FX_BITS-1:0]     f10;

	// Finish pipeline
	logic [EM_BITS-1:0]     whole100_s1;
	logic [FTERM_BITS-1:0]  fterm_s1, fterm;
	unit_t                  code_s1, code;
	logic                   neg_s1;
	logic [WHOLE_BITS-1:0]  whole_s1;
	logic [EM_BITS-1:0]     em100_s2;
	logic [DW-1:0]          div_q, div_nx;
	logic [3:0]             rem_q, rem_nx;
	logic [4:0]             r5;
	logic [CMP_BITS-1:0]    pct_sel;
	logic [2:0]             fd3;

	// Next intake state for the offered character
	always_comb begin
		ph_nx    = phase_q;
		neg_nx   = neg_q;
		seen_nx  = seen_q;
		whole_nx = whole_q;
		frac_nx  = frac_q;
		fd_nx    = fd_q;
		ulen_nx  = ulen_q;
		add_unit = 1'b0;
		for (int i = 0; i < UNIT_CHARS; i++) begin
			unit_nx[i] = unit_q[i];
		end
		is_digit = (ch >= CH_0) && (ch <= CH_9);
		w10 = WX_BITS'(whole_q) * WX_BITS'(10) + WX_BITS'(ch[3:0]);
		f10 = FX_BITS'(frac_q) * FX_BITS'(10) + FX_BITS'(ch[3:0]);
		if (phase_q == PH_SIGN && (ch == CH_MINUS || ch == CH_PLUS)) begin
			ph_nx  = PH_WHOLE;
			neg_nx = (ch == CH_MINUS);
		end else begin
			case (phase_q)
				PH_SIGN, PH_WHOLE: begin
					ph_nx = PH_WHOLE;
					if (is_digit) begin
						whole_nx = (w10 > WX_BITS'(WHOLE_MAX)) ? WHOLE_MAX
							: w10[WHOLE_BITS-1:0];
						seen_nx  = 1'b1;
					end else if (ch == CH_DOT) begin
						ph_nx = PH_FRAC;
					end else begin
						ph_nx    = PH_UNIT;
						add_unit = 1'b1;
					end
				end
				PH_FRAC: begin
					if (is_digit && fd_q < FD_BITS'(MAX_FRAC_DIGITS)) begin
						frac_nx = f10[FRAC_BITS-1:0];
						fd_nx   = fd_q + 1'b1;
						seen_nx = 1'b1;
					end else begin
						ph_nx    = PH_UNIT;
						add_unit = 1'b1;
					end
				end
				default: begin
					add_unit = 1'b1;
				end
			endcase
		end
		if (add_unit) begin
			if (ulen_q < ULEN_BITS'(UNIT_CHARS)) begin
				unit_nx[ulen_q[1:0]] = ch;
			end
			if (ulen_q <= ULEN_BITS'(UNIT_CHARS)) begin
				ulen_nx = ulen_q + 1'b1;
			end
		end
	end

	// Hold the token; clear it once the finish pipeline has captured it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIGN;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			whole_q <= '0;
			frac_q  <= '0;
			fd_q    <= '0;
			ulen_q  <= '0;
			for (int i = 0; i < UNIT_CHARS; i++) begin
				unit_q[i] <= '0;
			end
		end else if (cmd.scale) begin
			phase_q <= PH_SIGN;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			whole_q <= '0;
			frac_q  <= '0;
			fd_q    <= '0;
			ulen_q  <= '0;
			for (int i = 0; i < UNIT_CHARS; i++) begin
				unit_q[i] <= '0;
			end
		end else if (cmd.take) begin
			phase_q <= ph_nx;
			neg_q   <= neg_nx;
			seen_q  <= seen_nx;
			whole_q <= whole_nx;
			frac_q  <= frac_nx;
			fd_q    <= fd_nx;
			ulen_q  <= ulen_nx;
			for (int i = 0; i < UNIT_CHARS; i++) begin
				unit_q[i] <= unit_nx[i];
			end
		end
	end

	// Recognize the unit
	always_comb begin
		if (!seen_q) begin
			code = U_BAD;
		end else if (ulen_q == '0 && whole_q == '0 && frac_q == '0) begin
			code = U_BARE;
		end else if (ulen_q == ULEN_BITS'(2) && unit_q[0] == CH_E && unit_q[1] == CH_M) begin
			code = U_EM;
		end else if (ulen_q == ULEN_BITS'(3) && unit_q[0] == CH_R && unit_q[1] == CH_E
				&& unit_q[2] == CH_M) begin
			code = U_REM;
		end else if (ulen_q == ULEN_BITS'(1) && unit_q[0] == CH_PCT) begin
			code = U_PCT;
		end else if (ulen_q == ULEN_BITS'(2) && unit_q[0] == CH_P && unit_q[1] == CH_X) begin
			code = U_PX;
		end else if (ulen_q == ULEN_BITS'(2) && unit_q[0] == CH_P && unit_q[1] == CH_T) begin
			code = U_PT;
		end else begin
			code = U_BAD;
		end
	end

	// Fraction in hundredths: scale up or divide by reciprocal multiply
	always_comb begin
		fd3 = 3'(fd_q);
		case (fd3)
			3'd1:    fterm = FTERM_BITS'(frac_q * 10);
			3'd2:    fterm = FTERM_BITS'(frac_q);
			3'd3:    fterm = FTERM_BITS'((32'(frac_q) * RECIP10) >> RECIP10_SH);
			3'd4:    fterm = FTERM_BITS'((32'(frac_q) * RECIP100) >> RECIP100_SH);
			default: fterm = '0;
		endcase
	end

	// Divide by 12, eight quotient bits a cycle
	always_comb begin
		div_nx = div_q;
		rem_nx = rem_q;
		r5     = '0;
		for (int i = 0; i < DIV_RADIX_BITS; i++) begin
			r5     = {rem_nx, div_nx[DW-1]};
			div_nx = {div_nx[DW-2:0], 1'b0};
			if (r5 >= 5'(PT_DIVISOR)) begin
				r5        = r5 - 5'(PT_DIVISOR);
				div_nx[0] = 1'b1;
			end
			rem_nx = r5[3:0];
		end
	end

	// Finish pipeline registers
	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			whole100_s1 <= EM_BITS'(whole_q) * EM_BITS'(EM_SCALE);
			fterm_s1    <= fterm;
			code_s1     <= code;
			neg_s1      <= neg_q;
			whole_s1    <= whole_q;
		end
		if (cmd.sum) begin
			em100_s2 <= whole100_s1 + EM_BITS'(fterm_s1);
			div_q    <= DW'(whole100_s1 + EM_BITS'(fterm_s1));
			rem_q    <= '0;
		end else if (cmd.div_step) begin
			div_q <= div_nx;
			rem_q <= rem_nx;
		end
	end

	assign sts.need_div = (code_s1 == U_PT);

	// Select the value for the unit
	always_comb begin
		case (code_s1)
			U_EM, U_REM: pct_sel = CMP_BITS'(em100_s2);
			U_PCT:       pct_sel = CMP_BITS'(whole_s1);
			U_PX:        pct_sel = CMP_BITS'(em100_s2 >> PX_SHIFT);
			U_PT:        pct_sel = CMP_BITS'(div_q[EM_BITS-1:0]);
			default:     pct_sel = '0;
		endcase
		if (neg_s1) begin
			pct_sel = '0;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pct_value     <= (pct_sel > CMP_BITS'(PCT_MAX)) ? PCT_MAX
				: pct_sel[PCT_BITS-1:0];
			usable        <= (code_s1 != U_BAD);
			root_relative <= (code_s1 == U_REM);
		end
	end

endmodule

// ----- rtl/lutp_ctrl.sv -----
// ----------------------------------------------------------------------------
// lutp_ctrl
// Controller: takes characters, sequences the finish steps of a token and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module lutp_ctrl import lutp_pkg::*; #(
	parameter int DIV_CYCLES = 3
) (
	input  logic clk,
	input  logic arst_n,
	input  logic tok_valid,
	input  logic tok_last,
	output logic tok_ready,
	output logic res_valid,
	input  logic res_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	localparam int CNT_BITS = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	state_t              state_q, state_nx;
	logic [CNT_BITS-1:0] cnt_q;
	logic                out_free;
	logic                res_valid_q;

	assign out_free  = !res_valid_q || res_ready;
	assign tok_ready = (state_q == ST_TAKE);
	assign res_valid = res_valid_q;

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_TAKE: begin
				if (tok_valid) begin
					cmd.take = 1'b1;
					if (tok_last) begin
						state_nx = ST_SCALE;
					end
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_nx  = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum  = 1'b1;
				state_nx = sts.need_div ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_BITS'(DIV_CYCLES - 1)) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_TAKE;
				end
			end
			default: begin
				state_nx = ST_TAKE;
			end
		endcase
	end

	// Advance state, divide counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_TAKE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the length unit to percent parser. Tokens are fed
// one character per transaction; a local parser model predicts the result of
// every closed token, and each result taken from the block is compared with
// the oldest prediction. Directed tokens come first. Random well-formed
// tokens and byte noise follow, with idle bursts on both channels, a long
// receiver stall, a full drain pause and a final stretch without idling.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lutp_pkg::*;

	localparam int WHOLE_MAX    = (1 << DEF_WHOLE_BITS) - 1;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 12;
	localparam int MAX_REPORTS  = 10;

	// Characters that make up near-miss units
	localparam logic [7:0] UNIT_POOL [11] = '{CH_E, CH_M, CH_R, CH_P, CH_X, CH_T,
		CH_PCT, CH_DOT, CH_PLUS, CH_MINUS, CH_0};

	typedef struct packed {
		logic [PCT_BITS-1:0] pct;
		logic                usable;
		logic                root;
	} pct_result_t;

	logic clk = 1'b0;
	logic arst_n;

	lutp_tok_if tok ();
	lutp_res_if res ();

	length_unit_to_percent_parser i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.tok   (tok.sink),
		.res   (res.source)
	);

	// Parser model state
	phase_t                    tok_phase;
	logic                      is_negative;
	logic                      have_digit;
	logic [DEF_WHOLE_BITS-1:0] whole_val;
	logic [9:0]                frac_val;
	logic [1:0]                frac_cnt;
	logic [7:0]                unit_buf [UNIT_CHARS];
	logic [ULEN_BITS-1:0]      unit_len;

	pct_result_t pending_pct [$];
	logic [7:0]  text_buf [$];

	bit src_idle  = 1'b1;
	bit snk_idle  = 1'b1;
	int hold_reqs = 0;

	int cycles      = 0;
	int mismatches  = 0;
	int chars_sent  = 0;
	int tokens_sent = 0;
	int results_ok  = 0;

	// Generate the clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// End the run on a hang
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending", cycles,
				pending_pct.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------------
	function automatic void clear_token();
		tok_phase   = PH_SIGN;
		is_negative = 1'b0;
		have_digit  = 1'b0;
		whole_val   = '0;
		frac_val    = '0;
		frac_cnt    = '0;
		unit_len    = '0;
		foreach (unit_buf[i])
			unit_buf[i] = '0;
	endfunction

	function automatic void add_unit(input logic [7:0] c);
		if (unit_len < UNIT_CHARS)
			unit_buf[unit_len[1:0]] = c;
		if (unit_len < 4)
			unit_len++;
	endfunction

	function automatic bit unit_matches(input int n, input logic [7:0] c0, input logic [7:0] c1,
		input logic [7:0] c2);
		logic [7:0] want [UNIT_CHARS];
		want = '{c0, c1, c2};
		if (unit_len != n)
			return 1'b0;
		for (int i = 0; i < n; i++)
			if (unit_buf[i] != want[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void absorb_char(input logic [7:0] c);
		bit          is_digit;
		int unsigned d;
		int unsigned w;
		is_digit = (c >= CH_0) && (c <= CH_9);
		d        = c - CH_0;
		// Only the first character may carry a sign
		if (tok_phase == PH_SIGN) begin
			tok_phase = PH_WHOLE;
			if (c == CH_MINUS || c == CH_PLUS) begin
				is_negative = (c == CH_MINUS);
				return;
			end
		end
		case (tok_phase)
			PH_WHOLE: begin
				if (is_digit) begin
					w          = whole_val * 10 + d;
					whole_val  = DEF_WHOLE_BITS'((w > WHOLE_MAX) ? WHOLE_MAX : w);
					have_digit = 1'b1;
				end else if (c == CH_DOT) begin
					tok_phase = PH_FRAC;
				end else begin
					tok_phase = PH_UNIT;
					add_unit(c);
				end
			end
			PH_FRAC: begin
				// Digits beyond the fraction limit start the unit
				if (is_digit && frac_cnt < DEF_MAX_FRAC_DIGITS) begin
					frac_val   = 10'(frac_val * 10 + d);
					frac_cnt++;
					have_digit = 1'b1;
				end else begin
					tok_phase = PH_UNIT;
					add_unit(c);
				end
			end
			default: add_unit(c);
		endcase
	endfunction

	function automatic pct_result_t percent_of_token();
		int unsigned div;
		int unsigned em100;
		int unsigned pct;
		bit          ok;
		bit          root;
		pct_result_t r;
		case (frac_cnt)
			2'd0:    div = 1;
			2'd1:    div = 10;
			2'd2:    div = 100;
			default: div = 1000;
		endcase
		em100 = whole_val * EM_SCALE + (frac_val * EM_SCALE) / div;
		ok    = 1'b1;
		root  = 1'b0;
		pct   = 0;
		if (!have_digit)
			ok = 1'b0;
		else if (unit_len == 0 && whole_val == 0 && frac_val == 0)
			pct = 0;
		else if (unit_matches(2, CH_E, CH_M, 8'h00))
			pct = em100;
		else if (unit_matches(3, CH_R, CH_E, CH_M)) begin
			pct  = em100;
			root = 1'b1;
		end else if (unit_matches(1, CH_PCT, 8'h00, 8'h00))
			pct = whole_val;
		else if (unit_matches(2, CH_P, CH_X, 8'h00))
			pct = em100 / (1 << PX_SHIFT);
		else if (unit_matches(2, CH_P, CH_T, 8'h00))
			pct = em100 / PT_DIVISOR;
		else
			ok = 1'b0;
		if (!ok) begin
			pct  = 0;
			root = 1'b0;
		end
		if (is_negative)
			pct = 0;
		if (pct > PCT_MAX)
			pct = PCT_MAX;
		r.pct    = PCT_BITS'(pct);
		r.usable = ok;
		r.root   = root;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Token source
	// ------------------------------------------------------------------------
	// Offer one character; predict once the transaction is accepted
	task automatic send_char(input logic [7:0] c, input logic l);
		int gap;
		if (src_idle && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			tok.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tok.valid <= 1'b1;
		tok.ch    <= c;
		tok.last  <= l;
		@(posedge clk);
		while (!tok.ready)
			@(posedge clk);
		absorb_char(c);
		chars_sent++;
		if (l) begin
			pending_pct.push_back(percent_of_token());
			clear_token();
			tokens_sent++;
		end
	endtask

	task automatic send_buf();
		for (int i = 0; i < text_buf.size(); i++)
			send_char(text_buf[i], i == text_buf.size() - 1);
	endtask

	task automatic send_text(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
		send_buf();
	endtask

	function automatic logic [7:0] rand_digit(input bit zero_only);
		return zero_only ? CH_0 : CH_0 + 8'($urandom_range(0, 9));
	endfunction

	// Build a mostly well-formed token with random content, else byte noise
	function automatic void build_token();
		int n;
		int pick;
		bit zeros;
		text_buf.delete();
		if ($urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 6);
			repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
			return;
		end
		zeros = ($urandom_range(0, 5) == 0);
		pick  = $urandom_range(0, 19);
		if (pick < 5)
			text_buf.push_back(CH_MINUS);
		else if (pick < 8)
			text_buf.push_back(CH_PLUS);
		pick = $urandom_range(0, 9);
		n    = (pick == 0) ? 0 : (pick < 8) ? $urandom_range(1, 3) : $urandom_range(4, 7);
		repeat (n) text_buf.push_back(rand_digit(zeros));
		if ($urandom_range(0, 9) < 4) begin
			text_buf.push_back(CH_DOT);
			n = $urandom_range(0, 5);
			repeat (n) text_buf.push_back(rand_digit(zeros));
		end
		case ($urandom_range(0, 9))
			0: ;
			1, 9: begin
				text_buf.push_back(CH_E);
				text_buf.push_back(CH_M);
			end
			2: begin
				text_buf.push_back(CH_R);
				text_buf.push_back(CH_E);
				text_buf.push_back(CH_M);
			end
			3: text_buf.push_back(CH_PCT);
			4: begin
				text_buf.push_back(CH_P);
				text_buf.push_back(CH_X);
			end
			5: begin
				text_buf.push_back(CH_P);
				text_buf.push_back(CH_T);
			end
			6, 7: begin
				n = $urandom_range(1, 4);
				repeat (n) text_buf.push_back(UNIT_POOL[$urandom_range(0, 10)]);
			end
			default: text_buf.push_back(8'($urandom_range(0, 255)));
		endcase
		if (text_buf.size() == 0)
			text_buf.push_back(8'($urandom_range(0, 255)));
	endfunction

	task automatic send_random_until(input int char_goal);
		while (chars_sent < char_goal) begin
			build_token();
			send_buf();
		end
	endtask

	// ------------------------------------------------------------------------
	// Result sink
	// ------------------------------------------------------------------------
	// Drive ready: long hold on request, random stall bursts otherwise
	initial begin
		int gap_left;
		int hold_left;
		int holds_seen;
		gap_left   = 0;
		hold_left  = 0;
		holds_seen = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_seen) begin
				holds_seen = hold_reqs;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				res.ready <= 1'b0;
			end else if (snk_idle && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(1, 9) - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	task automatic flag_mismatch(input string what, input int unsigned want,
		input int unsigned got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		pct_result_t want;
		if (arst_n && res.valid && res.ready) begin
			if (pending_pct.size() == 0) begin
				flag_mismatch("result with no token pending, pct_value", 0, res.pct_value);
			end else begin
				want = pending_pct.pop_front();
				if (res.pct_value !== want.pct)
					flag_mismatch("pct_value", want.pct, res.pct_value);
				if (res.usable !== want.usable)
					flag_mismatch("usable", want.usable, res.usable);
				if (res.root_relative !== want.root)
					flag_mismatch("root_relative", want.root, res.root_relative);
				results_ok++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Every unit, both signs, bare zero, saturation, leading dot, no digits
	task automatic test_directed();
		send_text("0");
		send_text("+1.5em");
		send_text("-2rem");
		send_text("7.9%");
		send_text("99999px");
		send_text(".5pt");
		send_text("x");
	endtask

	task automatic test_random(input int char_goal);
		send_random_until(char_goal);
	endtask

	// Stall the receiver for a long stretch while characters keep coming
	task automatic test_backpressure(input int n_tokens);
		src_idle  <= 1'b0;
		hold_reqs <= hold_reqs + 1;
		repeat (n_tokens) begin
			build_token();
			send_buf();
		end
		src_idle <= 1'b1;
	endtask

	// Hold the source until every pending result has drained
	task automatic test_drain_pause(input int char_goal);
		send_random_until(char_goal);
		tok.valid <= 1'b0;
		while (pending_pct.size() != 0)
			@(posedge clk);
	endtask

	// Run back to back on both channels
	task automatic test_full_rate(input int char_goal);
		src_idle <= 1'b0;
		snk_idle <= 1'b0;
		send_random_until(char_goal);
	endtask

	initial begin
		arst_n    <= 1'b0;
		tok.valid <= 1'b0;
		tok.ch    <= '0;
		tok.last  <= 1'b0;
		clear_token();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(1300);
		test_backpressure(40);
		test_drain_pause(1450);
		test_random(1700);
		test_full_rate(1950);

		// Drain the results, then allow for the block's latency
		tok.valid <= 1'b0;
		while (pending_pct.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Parsed %0d tokens from %0d characters, %0d results checked",
			tokens_sent, chars_sent, results_ok);
		$display("Covered all units, signs, noise bytes, stalls and a full-rate stretch");
		if (mismatches == 0 && pending_pct.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
